// ----- hdl/apvt_pkg.sv -----
package apvt_pkg;

  localparam int unsigned ALT_W   = 16;
  localparam int unsigned PERIOD_W = 16;
  // |delta * 1000| <= 32768000 fits 25 magnitude bits plus sign
  localparam int unsigned PROD_W  = 26;
  localparam int unsigned DIV_W   = 25;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [PROD_W-1:0] VELO_SCALE = 26'sd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ARM    = 1'b1;

  localparam logic [1:0] KIND_ALTITUDE = 2'd0;
  localparam logic [1:0] KIND_CAPTURED = 2'd1;
  localparam logic [1:0] KIND_ARMED    = 2'd2;

  localparam logic [PERIOD_W-1:0] OSR_T0 = 16'd11;
  localparam logic [PERIOD_W-1:0] OSR_T1 = 16'd19;
  localparam logic [PERIOD_W-1:0] OSR_T2 = 16'd35;
  localparam logic [PERIOD_W-1:0] OSR_T3 = 16'd67;
  localparam logic [PERIOD_W-1:0] OSR_T4 = 16'd131;
  localparam logic [PERIOD_W-1:0] OSR_T5 = 16'd259;
  localparam logic [PERIOD_W-1:0] OSR_T6 = 16'd513;

  typedef struct packed {
    logic                    opcode;
    logic signed [ALT_W-1:0] altitude_raw;
  } apvt_in_t;

  typedef struct packed {
    logic [1:0]              report_kind;
    logic signed [ALT_W-1:0] altitude_now;
    logic signed [ALT_W-1:0] altitude_peak;
    logic signed [ALT_W-1:0] climb_rate;
    logic signed [ALT_W-1:0] climb_rate_peak;
    logic [2:0]              oversample_code;
  } apvt_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } apvt_div_status_t;

  function automatic logic [2:0] osr_code(input logic [PERIOD_W-1:0] p);
    logic [2:0] code;
    priority if (p <= OSR_T0) code = 3'd0;
    else if (p <= OSR_T1) code = 3'd1;
    else if (p <= OSR_T2) code = 3'd2;
    else if (p <= OSR_T3) code = 3'd3;
    else if (p <= OSR_T4) code = 3'd4;
    else if (p <= OSR_T5) code = 3'd5;
    else if (p <= OSR_T6) code = 3'd6;
    else code = 3'd7;
    return code;
  endfunction

endpackage

// ----- hdl/altitude_peak_velocity_tracker.sv -----
// Altitude and climb-rate tracker for a barometric altimeter.
// Input channel (in_valid_i/in_ready_o/in_data_i): each transaction is an
// altitude sample or a request to arm ground calibration. Output channel
// (out_valid_o/out_ready_i/out_data_o): exactly one report per input.
// cfg_we_i/cfg_data_i write the sample period in ms; write it only while idle.
// The block takes one transaction at a time. An arm request or a ground
// capture goes straight to delivery, skipping the arithmetic. For an altitude
// sample the change is multiplied by 1000, then the period is checked: a zero
// period skips the division, else the bit-serial restoring divider forms the
// 25-bit quotient. in_ready_o rises again as soon as the result moves
// into the output register, so a new transaction can start while the
// receiver still holds off the last report. If the receiver stalls, the
// finished report waits in the sequencer until the output register frees
// up. Reset clears ground level, peaks and the arm flag, sets the period
// to 100 and leaves both channels empty.
module altitude_peak_velocity_tracker import apvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apvt_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apvt_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SIGN,
    S_DIV,
    S_DELIVER
  } state_e;

  state_e state_q;

  logic [PERIOD_W-1:0]     period_q;
  logic [ALT_W-1:0]        ground_q;
  logic                    armed_q;
  logic signed [ALT_W-1:0] cur_alt_q;
  logic signed [ALT_W-1:0] peak_alt_q;
  logic signed [ALT_W-1:0] peak_rate_q;
  logic signed [ALT_W-1:0] delta_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    div_start_q;
  apvt_out_t               res_q;
  apvt_out_t               out_q;
  logic                    out_valid_q;

  logic signed [ALT_W-1:0]  new_alt;
  logic signed [ALT_W-1:0]  delta;
  logic signed [ALT_W-1:0]  peak_alt_new;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic                     prod_neg;
  logic signed [ALT_W-1:0]  rate;
  logic [DIV_W-1:0]         quotient;
  apvt_div_status_t         div_stat;
  logic                     in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Altitude above ground and the change since the last sample, both wrap.
  always_comb begin
    new_alt      = in_data_i.altitude_raw - $signed(ground_q);
    delta        = new_alt - cur_alt_q;
    peak_alt_new = (new_alt > peak_alt_q) ? new_alt : peak_alt_q;
  end

  assign prod     = PROD_W'(delta_q) * VELO_SCALE;
  assign prod_neg = prod_q[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-prod_q) : prod_q;

  // Truncating signed division: divide magnitudes, restore the sign, wrap.
  assign rate = prod_neg ? -$signed(quotient[ALT_W-1:0]) : $signed(quotient[ALT_W-1:0]);

  apvt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_mag[DIV_W-1:0]),
    .divisor_i  (period_q),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= PERIOD_RESET;
      ground_q    <= '0;
      armed_q     <= 1'b0;
      cur_alt_q   <= '0;
      peak_alt_q  <= '0;
      peak_rate_q <= '0;
      delta_q     <= '0;
      prod_q      <= '0;
      div_start_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      // Drop the report once the receiver takes it.
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_q.report_kind     <= KIND_ALTITUDE;
            res_q.altitude_now    <= cur_alt_q;
            res_q.altitude_peak   <= peak_alt_q;
            res_q.climb_rate      <= '0;
            res_q.climb_rate_peak <= peak_rate_q;
            res_q.oversample_code <= '0;
            if (in_data_i.opcode == OP_ARM) begin
              armed_q           <= 1'b1;
              res_q.report_kind <= KIND_ARMED;
              state_q           <= S_DELIVER;
            end else if (armed_q) begin
              ground_q          <= in_data_i.altitude_raw;
              armed_q           <= 1'b0;
              res_q.report_kind <= KIND_CAPTURED;
              state_q           <= S_DELIVER;
            end else begin
              cur_alt_q           <= new_alt;
              peak_alt_q          <= peak_alt_new;
              delta_q             <= delta;
              res_q.altitude_now  <= new_alt;
              res_q.altitude_peak <= peak_alt_new;
              state_q             <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= prod;
          state_q <= S_SIGN;
        end
        S_SIGN: begin
          // A zero period skips the division and reports a rate of zero.
          if (period_q == '0) begin
            state_q <= S_DELIVER;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          div_start_q <= 1'b0;
          if (div_stat.done) begin
            res_q.climb_rate <= rate;
            if (rate > peak_rate_q) begin
              peak_rate_q           <= rate;
              res_q.climb_rate_peak <= rate;
            end
            state_q <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          // Hold the report until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_q                 <= res_q;
            out_q.oversample_code <= osr_code(period_q);
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("input accepted while divider busy");

  a_arm_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.opcode == OP_ARM) |=> armed_q)
    else $error("arm request did not set calibration flag");

  a_peak_covers_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.report_kind == KIND_ALTITUDE)
      |-> (out_data_o.altitude_peak >= out_data_o.altitude_now))
    else $error("peak altitude below current altitude");

  a_rate_zero_other_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.report_kind != KIND_ALTITUDE)
      |-> (out_data_o.climb_rate == '0))
    else $error("nonzero climb rate on calibration report");

endmodule

// ----- hdl/apvt_divider.sv -----
module apvt_divider import apvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_W-1:0]    dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output apvt_div_status_t    status_o,
  output logic [DIV_W-1:0]    quotient_o
);

  logic [DIV_W-1:0]     dvd_q;
  logic [PERIOD_W-1:0]  dvs_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic [PERIOD_W-1:0]  rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [PERIOD_W:0]    shifted;
  logic                 q_bit;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem_q, dvd_q[DIV_W-1]};
    q_bit   = (shifted >= {1'b0, dvs_q});
    if (q_bit) begin
      rem_d = PERIOD_W'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = shifted[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
      cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule
